@@ hdl/pdw_pkg.sv @@
// ----------------------------------------------------------------------------
// Pair density weight evaluator: shared package
// Sizes of the stores, field widths, action and register codes, the stage
// structs and the saturating Q8.24 multiply.
// ----------------------------------------------------------------------------
`default_nettype none

package pdw_pkg;

   // Sizes of the chain and of the density tables.
   localparam int MAX_BEADS  = 64;
   localparam int MAX_ROTORS = 16;
   localparam int MAX_L      = 4;
   localparam int GMAX       = 2 * MAX_L + 1;
   localparam int PMAX       = GMAX * GMAX;
   localparam int GRID_DEPTH = (MAX_BEADS + 1) * MAX_ROTORS;
   localparam int FREE_DEPTH = GMAX * GMAX;
   localparam int PAIR_DEPTH = PMAX * PMAX;
   localparam int GRID_AW    = $clog2(GRID_DEPTH);
   localparam int FREE_AW    = $clog2(FREE_DEPTH);
   localparam int PAIR_AW    = $clog2(PAIR_DEPTH);

   // Field and register widths.
   localparam int BEAD_W = 7;
   localparam int ROTOR_W = 4;
   localparam int ROW_W  = 7;
   localparam int VAL_W  = 32;
   localparam int GIDX_W = 4;
   localparam int NB_W   = 7;
   localparam int NR_W   = 5;
   localparam int ML_W   = 3;
   localparam int GW     = $clog2(GMAX + 1);
   localparam int IW     = $clog2(PMAX);
   localparam int CSR_IW = 2;
   localparam int CSR_DW = 7;

   localparam logic [VAL_W-1:0] ONE_Q24 = 32'h0100_0000;
   localparam logic [VAL_W-1:0] SAT_MAX = 32'hFFFF_FFFF;

   // Register indexes of the configuration port.
   localparam logic [CSR_IW-1:0] CSR_NUM_BEADS  = 2'd0;
   localparam logic [CSR_IW-1:0] CSR_NUM_ROTORS = 2'd1;
   localparam logic [CSR_IW-1:0] CSR_MAX_L      = 2'd2;

   typedef enum logic [1:0] {
      ACT_GRID = 2'd0,
      ACT_FREE = 2'd1,
      ACT_PAIR = 2'd2,
      ACT_EVAL = 2'd3
   } action_type;

   // Effective configuration after clamping.
   typedef struct packed {
      logic [NB_W-1:0] nb;
      logic [NR_W-1:0] nr;
      logic [GW-1:0]   g;
   } cfg_type;

   // Factors of one evaluation, absent ones already set to 1.0.
   typedef struct packed {
      logic             bad;
      logic [VAL_W-1:0] f0;
      logic [VAL_W-1:0] f1;
      logic [VAL_W-1:0] pa;
      logic [VAL_W-1:0] pb;
      logic [VAL_W-1:0] pc;
      logic [VAL_W-1:0] pd;
   } factor_type;

   typedef struct packed {
      logic [VAL_W-1:0] value;
      logic             sat;
   } qprod_type;

   // Q8.24 product, truncated, saturating to all ones.
   function automatic qprod_type qmul(input logic [VAL_W-1:0] a, input logic [VAL_W-1:0] b);
      logic [2*VAL_W-1:0] prod;
      qprod_type          res;
      prod = (2*VAL_W)'(a) * (2*VAL_W)'(b);
      res.sat = (prod[2*VAL_W-1:VAL_W+24] != '0);
      res.value = res.sat ? SAT_MAX : prod[VAL_W+23:24];
      return res;
   endfunction

endpackage

`default_nettype wire

@@ hdl/pair_density_weight_eval_core.sv @@
// ----------------------------------------------------------------------------
// Pair density weight evaluator core
// Stores the orientation grid and density tables and evaluates weights.
// ----------------------------------------------------------------------------
// Usage:
// Items arrive on the req_ channel (valid/ready); each transfer is either a
// write to the orientation grid, the free density table or the pair density
// table, or an evaluate. Each evaluate gives one transfer on the rsp_
// channel with the weight, the saturation flag and the status; writes give
// none. The csr_ port sets the last bead index, rotor count and angular
// cutoff; the user must write it only while idle, unchecked by the block.
// An evaluate passes through the lookup stages and then the multiply stages
// before rsp_valid rises. One item can enter every cycle unless the receiver
// stalls: the grid is held in nine copies, the free table in two and the pair
// table in four, so every lookup of an evaluate has a read port of its own,
// and the five Q8.24 products run in four pipeline stages.
// Reset empties the pipeline and sets the registers to one bead index, one
// rotor and a cutoff of four; the tables are not cleared and hold what was
// last written. When the receiver stalls, each stage holds its item and the
// input keeps taking items until the pipeline is full.
// ----------------------------------------------------------------------------
`default_nettype none

module pair_density_weight_eval_core import pdw_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_wr_en,
   input  wire logic [CSR_IW-1:0]  csr_index,
   input  wire logic [CSR_DW-1:0]  csr_wdata,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [1:0]         req_action,
   input  wire logic [BEAD_W-1:0]  req_bead,
   input  wire logic [ROTOR_W-1:0] req_rotor,
   input  wire logic [ROW_W-1:0]   req_row,
   input  wire logic [ROW_W-1:0]   req_col,
   input  wire logic [VAL_W-1:0]   req_value,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [VAL_W-1:0]        rsp_weight,
   output logic                    rsp_saturated,
   output logic                    rsp_status
);

   logic [NB_W-1:0] num_beads_ff;
   logic [NR_W-1:0] num_rotors_ff;
   logic [ML_W-1:0] max_l_ff;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         num_beads_ff  <= NB_W'(1);
         num_rotors_ff <= NR_W'(1);
         max_l_ff      <= ML_W'(4);
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_NUM_BEADS:  num_beads_ff  <= csr_wdata[NB_W-1:0];
            CSR_NUM_ROTORS: num_rotors_ff <= csr_wdata[NR_W-1:0];
            CSR_MAX_L:      max_l_ff      <= csr_wdata[ML_W-1:0];
            default: ;
         endcase
      end
   end

   // Clamp the registers to the sizes of the stores.
   cfg_type cfg;
   logic [ML_W-1:0] ml_eff;
   assign cfg.nb = (int'(num_beads_ff) > MAX_BEADS) ? NB_W'(MAX_BEADS) : num_beads_ff;
   assign cfg.nr = (int'(num_rotors_ff) > MAX_ROTORS) ? NR_W'(MAX_ROTORS) : num_rotors_ff;
   assign ml_eff = (int'(max_l_ff) > MAX_L) ? ML_W'(MAX_L) : max_l_ff;
   assign cfg.g  = GW'({ml_eff, 1'b1});

   logic       fx_valid, fx_ready;
   factor_type fx_data;

   pdw_fetch u_fetch (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_action (req_action),
      .req_bead   (req_bead),
      .req_rotor  (req_rotor),
      .req_row    (req_row),
      .req_col    (req_col),
      .req_value  (req_value),
      .out_valid  (fx_valid),
      .out_ready  (fx_ready),
      .out_data   (fx_data)
   );

   pdw_mult u_mult (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (fx_valid),
      .in_ready      (fx_ready),
      .in_data       (fx_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_weight    (rsp_weight),
      .rsp_saturated (rsp_saturated),
      .rsp_status    (rsp_status)
   );

endmodule

`default_nettype wire

@@ hdl/pdw_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pdw_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ hdl/pdw_fetch.sv @@
// ----------------------------------------------------------------------------
// Pair density weight evaluator: lookup stages
// Grid reads, free density reads and pair density reads in three stages,
// with the table writes applied at the stage that reads that table.
// ----------------------------------------------------------------------------
`default_nettype none

module pdw_fetch import pdw_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire cfg_type            cfg,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [1:0]         req_action,
   input  wire logic [BEAD_W-1:0]  req_bead,
   input  wire logic [ROTOR_W-1:0] req_rotor,
   input  wire logic [ROW_W-1:0]   req_row,
   input  wire logic [ROW_W-1:0]   req_col,
   input  wire logic [VAL_W-1:0]   req_value,
   output logic                    out_valid,
   input  wire logic               out_ready,
   output factor_type              out_data
);

   // Combined grid index x*g+y.
   function automatic logic [IW-1:0] pidx(input logic [GW-1:0] x, input logic [GW-1:0] y,
                                          input logic [GW-1:0] g);
      logic [2*GW-1:0] t;
      t = (2*GW)'(x) * (2*GW)'(g) + (2*GW)'(y);
      return IW'(t);
   endfunction

   logic ready1, ready2, ready3;

   // Stage 1 registers.
   logic v1_ff;
   action_type act1_ff;
   logic bad1_ff, hn1_ff, hp1_ff, hrp1_ff, hrm1_ff;
   logic [ROW_W-1:0] row1_ff, col1_ff;
   logic [VAL_W-1:0] val1_ff;

   // Stage 2 registers.
   logic v2_ff;
   action_type act2_ff;
   logic bad2_ff, hn2_ff, hp2_ff, hrp2_ff, hrm2_ff;
   logic [ROW_W-1:0] row2_ff, col2_ff;
   logic [VAL_W-1:0] val2_ff;
   logic [IW-1:0] ia_ff, ib_ff, ic_ff, id_ff, ie_ff, ih_ff;

   // Stage 3 registers.
   logic v3_ff;
   action_type act3_ff;
   logic bad3_ff, hn3_ff, hp3_ff, hrp3_ff, hrm3_ff;
   logic [VAL_W-1:0] fr0_ff, fr1_ff;

   // Ready chain: a stage takes a new item when empty or when it moves on.
   assign ready3 = !v3_ff || (act3_ff != ACT_EVAL) || out_ready;
   assign ready2 = !v2_ff || ready3;
   assign ready1 = !v1_ff || ready2;
   assign req_ready = ready1;

   // Range checks and neighbor flags at the input.
   logic bad_in, hn_in, hp_in, hrp_in, hrm_in, accept;
   assign accept = req_valid && ready1;
   assign bad_in = (cfg.nb == '0) || (req_bead > cfg.nb) || (NR_W'(req_rotor) >= cfg.nr);
   assign hn_in  = (req_bead < cfg.nb);
   assign hp_in  = (req_bead != '0);
   assign hrp_in = ((NR_W'(req_rotor) + NR_W'(1)) < cfg.nr);
   assign hrm_in = (req_rotor != '0);

   // Grid write at the input edge.
   logic grid_we;
   logic [GRID_AW-1:0] grid_wa;
   assign grid_we = accept && (action_type'(req_action) == ACT_GRID) &&
                    (int'(req_bead) <= MAX_BEADS) && (int'(req_rotor) < MAX_ROTORS);
   assign grid_wa = GRID_AW'(int'(req_bead) * MAX_ROTORS + int'(req_rotor));

   // Nine grid copies, one for each neighbor of the bead and rotor.
   logic [GIDX_W-1:0] grid_q [9];
   logic [GW-1:0]     gp [9];
   for (genvar db = 0; db < 3; db++) begin : g_bead
      for (genvar dr = 0; dr < 3; dr++) begin : g_rot
         logic [GRID_AW-1:0] ra;
         assign ra = GRID_AW'((int'(req_bead) + db - 1) * MAX_ROTORS +
                              int'(req_rotor) + dr - 1);
         pdw_ram #(.WIDTH(GIDX_W), .DEPTH(GRID_DEPTH)) u_grid (
            .clock   (clock),
            .wr_en   (grid_we),
            .wr_addr (grid_wa),
            .wr_data (req_value[GIDX_W-1:0]),
            .rd_en   (ready1),
            .rd_addr (ra),
            .rd_data (grid_q[db*3+dr])
         );
         // A stored index past the grid reads as the last point.
         assign gp[db*3+dr] = (GW'(grid_q[db*3+dr]) >= cfg.g) ? cfg.g - GW'(1)
                                                              : GW'(grid_q[db*3+dr]);
      end
   end

   // Stage 1 register.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (ready1) begin
         v1_ff <= req_valid;
      end
      if (ready1) begin
         act1_ff <= action_type'(req_action);
         bad1_ff <= bad_in;
         hn1_ff  <= hn_in;
         hp1_ff  <= hp_in;
         hrp1_ff <= hrp_in;
         hrm1_ff <= hrm_in;
         row1_ff <= req_row;
         col1_ff <= req_col;
         val1_ff <= req_value;
      end
   end

   // Names of the clamped grid points around the bead and rotor.
   logic [GW-1:0] cur, nx, pv, rp, nrp, prp, rm, nrm, prm;
   assign prm = gp[0];
   assign pv  = gp[1];
   assign prp = gp[2];
   assign rm  = gp[3];
   assign cur = gp[4];
   assign rp  = gp[5];
   assign nrm = gp[6];
   assign nx  = gp[7];
   assign nrp = gp[8];

   // Free density reads and write at the edge into stage 2.
   logic free_we;
   logic [FREE_AW-1:0] free_wa, free_ra0, free_ra1;
   logic [VAL_W-1:0] free_q0, free_q1;
   assign free_we = ready2 && v1_ff && (act1_ff == ACT_FREE) &&
                    (int'(row1_ff) < GMAX) && (int'(col1_ff) < GMAX);
   assign free_wa  = FREE_AW'(int'(row1_ff) * GMAX + int'(col1_ff));
   assign free_ra0 = FREE_AW'(int'(cur) * GMAX + int'(nx));
   assign free_ra1 = FREE_AW'(int'(pv) * GMAX + int'(cur));

   pdw_ram #(.WIDTH(VAL_W), .DEPTH(FREE_DEPTH)) u_free0 (
      .clock (clock), .wr_en (free_we), .wr_addr (free_wa), .wr_data (val1_ff),
      .rd_en (ready2), .rd_addr (free_ra0), .rd_data (free_q0)
   );
   pdw_ram #(.WIDTH(VAL_W), .DEPTH(FREE_DEPTH)) u_free1 (
      .clock (clock), .wr_en (free_we), .wr_addr (free_wa), .wr_data (val1_ff),
      .rd_en (ready2), .rd_addr (free_ra1), .rd_data (free_q1)
   );

   // Stage 2 register with the combined pair indices.
   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (ready2) begin
         v2_ff <= v1_ff;
      end
      if (ready2) begin
         act2_ff <= act1_ff;
         bad2_ff <= bad1_ff;
         hn2_ff  <= hn1_ff;
         hp2_ff  <= hp1_ff;
         hrp2_ff <= hrp1_ff;
         hrm2_ff <= hrm1_ff;
         row2_ff <= row1_ff;
         col2_ff <= col1_ff;
         val2_ff <= val1_ff;
         ia_ff   <= pidx(cur, rp, cfg.g);
         ib_ff   <= pidx(nx, nrp, cfg.g);
         ic_ff   <= pidx(pv, prp, cfg.g);
         id_ff   <= pidx(rm, cur, cfg.g);
         ie_ff   <= pidx(nrm, nx, cfg.g);
         ih_ff   <= pidx(prm, pv, cfg.g);
      end
   end

   // Pair density reads and write at the edge into stage 3.
   logic pair_we;
   logic [PAIR_AW-1:0] pair_wa;
   logic [PAIR_AW-1:0] pair_ra [4];
   logic [VAL_W-1:0]   pair_q [4];
   assign pair_we = ready3 && v2_ff && (act2_ff == ACT_PAIR) &&
                    (int'(row2_ff) < PMAX) && (int'(col2_ff) < PMAX);
   assign pair_wa    = PAIR_AW'(int'(row2_ff) * PMAX + int'(col2_ff));
   assign pair_ra[0] = PAIR_AW'(int'(ia_ff) * PMAX + int'(ib_ff));
   assign pair_ra[1] = PAIR_AW'(int'(ic_ff) * PMAX + int'(ia_ff));
   assign pair_ra[2] = PAIR_AW'(int'(id_ff) * PMAX + int'(ie_ff));
   assign pair_ra[3] = PAIR_AW'(int'(ih_ff) * PMAX + int'(id_ff));

   for (genvar k = 0; k < 4; k++) begin : g_pair
      pdw_ram #(.WIDTH(VAL_W), .DEPTH(PAIR_DEPTH)) u_pair (
         .clock (clock), .wr_en (pair_we), .wr_addr (pair_wa), .wr_data (val2_ff),
         .rd_en (ready3), .rd_addr (pair_ra[k]), .rd_data (pair_q[k])
      );
   end

   // Stage 3 register; the free data moves along beside the pair reads.
   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (ready3) begin
         v3_ff <= v2_ff;
      end
      if (ready3) begin
         act3_ff <= act2_ff;
         bad3_ff <= bad2_ff;
         hn3_ff  <= hn2_ff;
         hp3_ff  <= hp2_ff;
         hrp3_ff <= hrp2_ff;
         hrm3_ff <= hrm2_ff;
         fr0_ff  <= free_q0;
         fr1_ff  <= free_q1;
      end
   end

   // Only evaluations go on; absent neighbors contribute 1.0.
   assign out_valid   = v3_ff && (act3_ff == ACT_EVAL);
   assign out_data.bad = bad3_ff;
   assign out_data.f0 = hn3_ff ? fr0_ff : ONE_Q24;
   assign out_data.f1 = hp3_ff ? fr1_ff : ONE_Q24;
   assign out_data.pa = (hrp3_ff && hn3_ff) ? pair_q[0] : ONE_Q24;
   assign out_data.pb = (hrp3_ff && hp3_ff) ? pair_q[1] : ONE_Q24;
   assign out_data.pc = (hrm3_ff && hn3_ff) ? pair_q[2] : ONE_Q24;
   assign out_data.pd = (hrm3_ff && hp3_ff) ? pair_q[3] : ONE_Q24;

endmodule

`default_nettype wire

@@ hdl/pdw_mult.sv @@
// ----------------------------------------------------------------------------
// Pair density weight evaluator: multiply chain
// Four stages of saturating Q8.24 products in the fixed order of the
// weight, ending in the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module pdw_mult import pdw_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        in_valid,
   output logic             in_ready,
   input  wire factor_type  in_data,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [VAL_W-1:0] rsp_weight,
   output logic             rsp_saturated,
   output logic             rsp_status
);

   logic ready4, ready5, ready6, ready7;
   logic v4_ff, v5_ff, v6_ff, v7_ff;
   logic bad4_ff, bad5_ff, bad6_ff;
   logic sat4_ff, sat5_ff, sat6_ff;
   logic [VAL_W-1:0] f4_ff, f5_ff, f6_ff, p4_ff, p5_ff, p6_ff;
   logic [VAL_W-1:0] pc4_ff, pd4_ff, pd5_ff;
   logic [VAL_W-1:0] weight_ff;
   logic sat7_ff, status_ff;

   // Ready chain back from the result register.
   assign ready7 = !v7_ff || rsp_ready;
   assign ready6 = !v6_ff || ready7;
   assign ready5 = !v5_ff || ready6;
   assign ready4 = !v4_ff || ready5;
   assign in_ready = ready4;

   qprod_type qf_in, qp_in, q5_in, q6_in, q7_in;
   assign qf_in = qmul(in_data.f0, in_data.f1);
   assign qp_in = qmul(in_data.pa, in_data.pb);
   assign q5_in = qmul(p4_ff, pc4_ff);
   assign q6_in = qmul(p5_ff, pd5_ff);
   assign q7_in = qmul(f6_ff, p6_ff);

   // Valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
      end else begin
         if (ready4) v4_ff <= in_valid;
         if (ready5) v5_ff <= v4_ff;
         if (ready6) v6_ff <= v5_ff;
         if (ready7) v7_ff <= v6_ff;
      end
   end

   // Product stages.
   always_ff @(posedge clock) begin
      if (ready4) begin
         f4_ff   <= qf_in.value;
         p4_ff   <= qp_in.value;
         sat4_ff <= qf_in.sat || qp_in.sat;
         bad4_ff <= in_data.bad;
         pc4_ff  <= in_data.pc;
         pd4_ff  <= in_data.pd;
      end
      if (ready5) begin
         f5_ff   <= f4_ff;
         p5_ff   <= q5_in.value;
         sat5_ff <= sat4_ff || q5_in.sat;
         bad5_ff <= bad4_ff;
         pd5_ff  <= pd4_ff;
      end
      if (ready6) begin
         f6_ff   <= f5_ff;
         p6_ff   <= q6_in.value;
         sat6_ff <= sat5_ff || q6_in.sat;
         bad6_ff <= bad5_ff;
      end
      // An out-of-range bead or rotor reports zero with the error status.
      if (ready7) begin
         weight_ff <= bad6_ff ? '0 : q7_in.value;
         sat7_ff   <= !bad6_ff && (sat6_ff || q7_in.sat);
         status_ff <= bad6_ff;
      end
   end

   assign rsp_valid     = v7_ff;
   assign rsp_weight    = weight_ff;
   assign rsp_saturated = sat7_ff;
   assign rsp_status    = status_ff;

endmodule

`default_nettype wire

@@ tb/pair_density_weight_eval_core_test.sv @@
// ----------------------------------------------------------------------------
// Pair density weight evaluator core: testbench
// Fills the orientation grid and density tables through the request channel,
// evaluates weights under several bead, rotor and cutoff settings, and checks
// each response against a Q8.24 predictor kept in step with accepted
// transfers. A table read is always preceded by a write of that entry.
// ----------------------------------------------------------------------------
`default_nettype none

module pair_density_weight_eval_core_test;
   import pdw_pkg::*;

   typedef struct packed {
      logic [VAL_W-1:0] weight;
      logic             sat;
      logic             status;
   } weight_rsp_type;

   typedef struct packed {
      action_type       act;
      logic [6:0]       bead;
      logic [3:0]       rotor;
      logic [6:0]       row;
      logic [6:0]       col;
      logic [VAL_W-1:0] value;
      logic             chk;
      weight_rsp_type   exp_r;
   } dir_row_type;

   localparam weight_rsp_type RSP_ERR = '{32'h0, 1'b0, 1'b1};
   localparam int DIR_ROWS    = 20;
   localparam int PHASES      = 9;
   localparam int PHASE_ITEMS = 92;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_wr_en = 1'b0;
   logic [CSR_IW-1:0]  csr_index = '0;
   logic [CSR_DW-1:0]  csr_wdata = '0;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [1:0]         req_action = '0;
   logic [BEAD_W-1:0]  req_bead = '0;
   logic [ROTOR_W-1:0] req_rotor = '0;
   logic [ROW_W-1:0]   req_row = '0;
   logic [ROW_W-1:0]   req_col = '0;
   logic [VAL_W-1:0]   req_value = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [VAL_W-1:0]   rsp_weight;
   logic               rsp_saturated;
   logic               rsp_status;

   pair_density_weight_eval_core i_dut (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_valid(req_valid), .req_ready(req_ready), .req_action(req_action),
      .req_bead(req_bead), .req_rotor(req_rotor), .req_row(req_row),
      .req_col(req_col), .req_value(req_value),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_weight(rsp_weight),
      .rsp_saturated(rsp_saturated), .rsp_status(rsp_status)
   );

   always #5 clock = ~clock;

   // Effective configuration, shared by the planner and the predictor.
   int cfg_nb = 1, cfg_nr = 1, cfg_g = 9;

   // Predictor state, updated on accepted transfers.
   logic [3:0]       mdl_grid [GRID_DEPTH];
   logic [VAL_W-1:0] mdl_free [FREE_DEPTH];
   logic [VAL_W-1:0] mdl_pair [PAIR_DEPTH];

   // Stimulus planning state: what has been sent so far.
   logic [3:0] plan_grid [GRID_DEPTH];
   bit         grid_set [GRID_DEPTH];
   bit         free_set [FREE_DEPTH];
   bit         pair_set [PAIR_DEPTH];

   // Table addresses touched by one evaluation, in product order.
   int rd_free [2];
   int rd_pair [4];
   int nf, np;
   bit mul_sat;

   weight_rsp_type weight_exp_q [$];
   bit             typed_flag_q [$];
   weight_rsp_type typed_rsp_q [$];

   int errors = 0;
   int sent = 0;
   int tx_idle = 0, rx_idle = 0;
   int hold_req = 0, hold_done = 0, hold_cnt = 0;

   function automatic bit in_range(int b, int r);
      return cfg_nb != 0 && b <= cfg_nb && r < cfg_nr;
   endfunction

   // Stored orientation index, clamped to the current grid size.
   function automatic int gval(bit plan, int b, int r);
      int v;
      v = plan ? plan_grid[b * MAX_ROTORS + r] : mdl_grid[b * MAX_ROTORS + r];
      return v >= cfg_g ? cfg_g - 1 : v;
   endfunction

   // Works out which free and pair entries an evaluation multiplies.
   function automatic void find_reads(bit plan, int b, int r);
      int cur, nxt, prv, here;
      bit hn, hp;
      nf = 0;
      np = 0;
      hn = b < cfg_nb;
      hp = b > 0;
      cur = gval(plan, b, r);
      nxt = hn ? gval(plan, b + 1, r) : 0;
      prv = hp ? gval(plan, b - 1, r) : 0;
      if (hn) begin
         rd_free[nf] = cur * GMAX + nxt;
         nf = nf + 1;
      end
      if (hp) begin
         rd_free[nf] = prv * GMAX + cur;
         nf = nf + 1;
      end
      if (r + 1 < cfg_nr) begin
         here = cur * cfg_g + gval(plan, b, r + 1);
         if (hn) begin
            rd_pair[np] = here * PMAX + nxt * cfg_g + gval(plan, b + 1, r + 1);
            np = np + 1;
         end
         if (hp) begin
            rd_pair[np] = (prv * cfg_g + gval(plan, b - 1, r + 1)) * PMAX + here;
            np = np + 1;
         end
      end
      if (r > 0) begin
         here = gval(plan, b, r - 1) * cfg_g + cur;
         if (hn) begin
            rd_pair[np] = here * PMAX + gval(plan, b + 1, r - 1) * cfg_g + nxt;
            np = np + 1;
         end
         if (hp) begin
            rd_pair[np] = (gval(plan, b - 1, r - 1) * cfg_g + prv) * PMAX + here;
            np = np + 1;
         end
      end
   endfunction

   // Truncating Q8.24 product with a sticky saturation flag.
   function automatic logic [VAL_W-1:0] q_mul(logic [VAL_W-1:0] a, logic [VAL_W-1:0] b);
      logic [63:0] p;
      p = ({32'h0, a} * {32'h0, b}) >> 24;
      if (p[63:32] != 0) begin
         mul_sat = 1'b1;
         return 32'hFFFF_FFFF;
      end
      return p[31:0];
   endfunction

   function automatic weight_rsp_type eval_weight(int b, int r);
      weight_rsp_type res;
      logic [VAL_W-1:0] f, p;
      int k;
      res = '0;
      if (!in_range(b, r)) begin
         res.status = 1'b1;
         return res;
      end
      mul_sat = 1'b0;
      find_reads(1'b0, b, r);
      f = ONE_Q24;
      p = ONE_Q24;
      for (k = 0; k < nf; k++) f = q_mul(f, mdl_free[rd_free[k]]);
      for (k = 0; k < np; k++) p = q_mul(p, mdl_pair[rd_pair[k]]);
      res.weight = q_mul(f, p);
      res.sat = mul_sat;
      return res;
   endfunction

   // Density values spread over small, near one, large and arbitrary.
   function automatic logic [VAL_W-1:0] rand_density();
      case ($urandom_range(3))
         0: return $urandom_range(0, 32'h00FF_FFFF);
         1: return $urandom_range(32'h0080_0000, 32'h0200_0000);
         2: return $urandom_range(32'h1000_0000, 32'hFFFF_FFFF);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [VAL_W-1:0] rand_index();
      logic [VAL_W-1:0] v;
      v = $urandom;
      v[3:0] = ($urandom_range(99) < 80) ? 4'($urandom_range(0, cfg_g - 1))
                                         : 4'($urandom_range(0, 15));
      return v;
   endfunction

   // Sends one item: records what the planner needs, then waits for transfer.
   task automatic issue(action_type a, int b, int r, int row, int col,
                        logic [VAL_W-1:0] v, bit chk = 1'b0, weight_rsp_type t = '0);
      int gap;
      gap = ($urandom_range(99) < tx_idle) ? $urandom_range(1, 3) : 0;
      case (a)
         ACT_GRID: if (b <= MAX_BEADS && r < MAX_ROTORS) begin
            plan_grid[b * MAX_ROTORS + r] = v[3:0];
            grid_set[b * MAX_ROTORS + r] = 1'b1;
         end
         ACT_FREE: if (row < GMAX && col < GMAX) free_set[row * GMAX + col] = 1'b1;
         ACT_PAIR: if (row < PMAX && col < PMAX) pair_set[row * PMAX + col] = 1'b1;
         default: begin
            typed_flag_q = {typed_flag_q, chk};
            typed_rsp_q = {typed_rsp_q, t};
         end
      endcase
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid  <= 1'b1;
      req_action <= a;
      req_bead   <= BEAD_W'(b);
      req_rotor  <= ROTOR_W'(r);
      req_row    <= ROW_W'(row);
      req_col    <= ROW_W'(col);
      req_value  <= v;
      do @(posedge clock); while (!req_ready);
      sent = sent + 1;
   endtask

   // Writes every grid cell and table entry an evaluation needs, then evaluates.
   task automatic eval_seq(int b, int r);
      int db, dr, k, cb, cr, n, m;
      int fa [2];
      int pa [4];
      if (in_range(b, r)) begin
         for (db = -1; db <= 1; db++)
            for (dr = -1; dr <= 1; dr++) begin
               cb = b + db;
               cr = r + dr;
               if (cb >= 0 && cb <= cfg_nb && cr >= 0 && cr < cfg_nr
                   && !grid_set[cb * MAX_ROTORS + cr])
                  issue(ACT_GRID, cb, cr, $urandom_range(127), $urandom_range(127),
                        rand_index());
            end
         // Take private copies: the predictor reuses the shared read lists.
         find_reads(1'b1, b, r);
         fa = rd_free;
         pa = rd_pair;
         m = nf;
         n = np;
         for (k = 0; k < m; k++)
            if (!free_set[fa[k]])
               issue(ACT_FREE, $urandom_range(127), $urandom_range(15),
                     fa[k] / GMAX, fa[k] % GMAX, rand_density());
         for (k = 0; k < n; k++)
            if (!pair_set[pa[k]])
               issue(ACT_PAIR, $urandom_range(127), $urandom_range(15),
                     pa[k] / PMAX, pa[k] % PMAX, rand_density());
      end
      issue(ACT_EVAL, b, r, $urandom_range(127), $urandom_range(127), $urandom);
   endtask

   task automatic write_reg(logic [CSR_IW-1:0] idx, int val);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DW'(val);
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Waits until the block holds no work, then applies a new setting.
   task automatic set_config(int nb, int nr, int ml);
      @(negedge clock);
      req_valid <= 1'b0;
      wait (weight_exp_q.size() == 0);
      repeat (12) @(posedge clock);
      write_reg(CSR_NUM_BEADS, nb);
      write_reg(CSR_NUM_ROTORS, nr);
      write_reg(CSR_MAX_L, ml);
      cfg_nb = nb > MAX_BEADS ? MAX_BEADS : nb;
      cfg_nr = nr > MAX_ROTORS ? MAX_ROTORS : nr;
      cfg_g = 2 * (ml > MAX_L ? MAX_L : ml) + 1;
   endtask

   // Receiver: random stalls, plus long hold-offs on request.
   always @(negedge clock) begin
      if (hold_req != hold_done && hold_cnt == 0) begin
         hold_cnt = 150;
         hold_done = hold_done + 1;
      end
      if (hold_cnt > 0) begin
         hold_cnt = hold_cnt - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rx_idle);
      end
   end

   // Checks responses against the oldest expectation and predicts new ones.
   always @(posedge clock) begin
      weight_rsp_type got, want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_weight, rsp_saturated, rsp_status};
            if (weight_exp_q.size() == 0) begin
               $display("%0t: unexpected response weight %h sat %b status %b",
                        $time, rsp_weight, rsp_saturated, rsp_status);
               errors = errors + 1;
            end else begin
               want = weight_exp_q.pop_front();
               if (got.weight !== want.weight) begin
                  $display("%0t: weight expected %h actual %h", $time, want.weight, got.weight);
                  errors = errors + 1;
               end
               if (got.sat !== want.sat) begin
                  $display("%0t: saturated expected %b actual %b", $time, want.sat, got.sat);
                  errors = errors + 1;
               end
               if (got.status !== want.status) begin
                  $display("%0t: status expected %b actual %b", $time, want.status, got.status);
                  errors = errors + 1;
               end
            end
         end
         if (req_valid && req_ready) begin
            case (action_type'(req_action))
               ACT_GRID: if (req_bead <= MAX_BEADS)
                  mdl_grid[req_bead * MAX_ROTORS + req_rotor] = req_value[3:0];
               ACT_FREE: if (req_row < GMAX && req_col < GMAX)
                  mdl_free[req_row * GMAX + req_col] = req_value;
               ACT_PAIR: if (req_row < PMAX && req_col < PMAX)
                  mdl_pair[req_row * PMAX + req_col] = req_value;
               default: begin
                  want = eval_weight(req_bead, req_rotor);
                  if (typed_flag_q.pop_front()) want = typed_rsp_q.pop_front();
                  else void'(typed_rsp_q.pop_front());
                  weight_exp_q = {weight_exp_q, want};
               end
            endcase
         end
      end
   end

   // Directed items under the reset setting (one bead index, one rotor, G = 9).
   dir_row_type dir_tab [DIR_ROWS] = '{
      '{ACT_EVAL, 7'd2,   4'd0,  7'd0,   7'd0,   32'h0,         1'b1, RSP_ERR},
      '{ACT_EVAL, 7'd0,   4'd15, 7'd0,   7'd0,   32'h0,         1'b1, RSP_ERR},
      '{ACT_EVAL, 7'd127, 4'd0,  7'd127, 7'd127, 32'hFFFF_FFFF, 1'b1, RSP_ERR},
      '{ACT_GRID, 7'd64,  4'd15, 7'd127, 7'd127, 32'h0000_000F, 1'b0, '0},
      '{ACT_GRID, 7'd65,  4'd0,  7'd0,   7'd0,   32'h0,         1'b0, '0},
      '{ACT_GRID, 7'd127, 4'd15, 7'd0,   7'd0,   32'hFFFF_FFFF, 1'b0, '0},
      '{ACT_GRID, 7'd0,   4'd0,  7'd0,   7'd0,   32'h1234_5673, 1'b0, '0},
      '{ACT_GRID, 7'd1,   4'd0,  7'd0,   7'd0,   32'hFFFF_FFFF, 1'b0, '0},
      '{ACT_FREE, 7'd0,   4'd0,  7'd3,   7'd8,   ONE_Q24,       1'b0, '0},
      '{ACT_FREE, 7'd0,   4'd0,  7'd9,   7'd0,   32'h0,         1'b0, '0},
      '{ACT_FREE, 7'd0,   4'd0,  7'd127, 7'd127, 32'hFFFF_FFFF, 1'b0, '0},
      '{ACT_PAIR, 7'd0,   4'd0,  7'd80,  7'd80,  32'hFFFF_FFFF, 1'b0, '0},
      '{ACT_PAIR, 7'd0,   4'd0,  7'd81,  7'd0,   32'h0,         1'b0, '0},
      '{ACT_PAIR, 7'd0,   4'd0,  7'd127, 7'd127, 32'h0,         1'b0, '0},
      '{ACT_EVAL, 7'd0,   4'd0,  7'd0,   7'd0,   32'h0,         1'b1, '{ONE_Q24, 1'b0, 1'b0}},
      '{ACT_EVAL, 7'd1,   4'd0,  7'd0,   7'd0,   32'h0,         1'b1, '{ONE_Q24, 1'b0, 1'b0}},
      '{ACT_FREE, 7'd0,   4'd0,  7'd3,   7'd8,   32'hFFFF_FFFF, 1'b0, '0},
      '{ACT_EVAL, 7'd0,   4'd0,  7'd0,   7'd0,   32'h0,         1'b1, '{SAT_MAX, 1'b0, 1'b0}},
      '{ACT_FREE, 7'd0,   4'd0,  7'd3,   7'd8,   32'h0,         1'b0, '0},
      '{ACT_EVAL, 7'd1,   4'd0,  7'd0,   7'd0,   32'h0,         1'b1, '{32'h0, 1'b0, 1'b0}}
   };

   // Bead, rotor and cutoff per phase; negative means pick at random.
   int phase_nb [PHASES] = '{0, 4, 64, 127, 1, 8, -1, -1, 2};
   int phase_nr [PHASES] = '{3, 3, 16, 31, 1, 2, -1, -1, 16};
   int phase_ml [PHASES] = '{2, 1, 4, 7, 0, 3, -1, -1, 4};

   initial begin
      int i, ph, start, k, nb, nr, ml;
      bit held, paused;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      tx_idle = 20;
      rx_idle = 71;
      for (i = 0; i < DIR_ROWS; i++)
         issue(dir_tab[i].act, dir_tab[i].bead, dir_tab[i].rotor, dir_tab[i].row,
               dir_tab[i].col, dir_tab[i].value, dir_tab[i].chk, dir_tab[i].exp_r);

      for (ph = 0; ph < PHASES; ph++) begin
         nb = phase_nb[ph] < 0 ? $urandom_range(1, 20) : phase_nb[ph];
         nr = phase_nr[ph] < 0 ? $urandom_range(1, 16) : phase_nr[ph];
         ml = phase_ml[ph] < 0 ? $urandom_range(0, 7) : phase_ml[ph];
         set_config(nb, nr, ml);
         tx_idle = ph < 3 ? 20 : (ph < 6 ? 71 : 0);
         rx_idle = ph < 3 ? 71 : (ph < 6 ? 20 : 0);
         start = sent;
         held = 1'b0;
         paused = 1'b0;
         while (sent - start < PHASE_ITEMS) begin
            // Long receiver hold-off while items keep coming.
            if ((ph == 4 || ph == 7) && !held && sent - start >= 30) begin
               hold_req = hold_req + 1;
               held = 1'b1;
            end
            // Sender pause until every response is back.
            if (ph == 5 && !paused && sent - start >= 40) begin
               @(negedge clock);
               req_valid <= 1'b0;
               wait (weight_exp_q.size() == 0);
               paused = 1'b1;
            end
            k = $urandom_range(99);
            if (k < 60)
               eval_seq($urandom_range(0, cfg_nb), $urandom_range(0, cfg_nr - 1));
            else if (k < 70)
               eval_seq($urandom_range(0, 127), $urandom_range(0, 15));
            else if (k < 85) begin
               case ($urandom_range(2))
                  0: issue(ACT_GRID, $urandom_range(0, cfg_nb), $urandom_range(0, cfg_nr - 1),
                           $urandom_range(127), $urandom_range(127), rand_index());
                  1: issue(ACT_FREE, $urandom_range(127), $urandom_range(15),
                           $urandom_range(0, cfg_g - 1), $urandom_range(0, cfg_g - 1),
                           rand_density());
                  default: issue(ACT_PAIR, $urandom_range(127), $urandom_range(15),
                                 $urandom_range(0, cfg_g * cfg_g - 1),
                                 $urandom_range(0, cfg_g * cfg_g - 1), rand_density());
               endcase
            end else
               issue(action_type'($urandom_range(0, 2)), $urandom_range(127),
                     $urandom_range(15), $urandom_range(127), $urandom_range(127), $urandom);
         end
      end

      @(negedge clock);
      req_valid <= 1'b0;
      wait (weight_exp_q.size() == 0);
      repeat (20) @(posedge clock);
      if (errors == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   // Run limit.
   initial begin
      #3_000_000;
      $display("%0t: timeout", $time);
      $display("*** FAILED ***");
      $finish;
   end

endmodule

`default_nettype wire
